[sv/fre_pkg.sv]
// Shared constants, codes and types of the four-register instruction executor.
`default_nettype none

package fre_pkg;

    // Sizes
    localparam int unsigned PROGRAM_DEPTH = 1024;
    localparam int unsigned PC_W          = 11;
    localparam int unsigned DATA_W        = 32;
    localparam int unsigned NUM_REGS      = 4;
    localparam int unsigned REG_IDX_W     = $clog2(NUM_REGS);
    localparam int unsigned OPC_W         = 4;
    localparam int unsigned ERR_W         = 2;
    localparam int unsigned DIV_CNT_W     = $clog2(DATA_W);

    // Largest usable program length
    localparam logic [PC_W-1:0] LEN_MAX = PC_W'(PROGRAM_DEPTH);

    // Opcodes
    localparam logic [OPC_W-1:0] OP_READ  = 4'd0;
    localparam logic [OPC_W-1:0] OP_PRINT = 4'd1;
    localparam logic [OPC_W-1:0] OP_MOV   = 4'd2;
    localparam logic [OPC_W-1:0] OP_ADD   = 4'd3;
    localparam logic [OPC_W-1:0] OP_SUB   = 4'd4;
    localparam logic [OPC_W-1:0] OP_MUL   = 4'd5;
    localparam logic [OPC_W-1:0] OP_DIV   = 4'd6;
    localparam logic [OPC_W-1:0] OP_JMP   = 4'd7;
    localparam logic [OPC_W-1:0] OP_JE    = 4'd8;
    localparam logic [OPC_W-1:0] OP_JNE   = 4'd9;
    localparam logic [OPC_W-1:0] OP_JG    = 4'd10;
    localparam logic [OPC_W-1:0] OP_JGE   = 4'd11;
    localparam logic [OPC_W-1:0] OP_JL    = 4'd12;
    localparam logic [OPC_W-1:0] OP_JLE   = 4'd13;

    // Error codes
    localparam logic [ERR_W-1:0] ERR_NONE     = 2'd0;
    localparam logic [ERR_W-1:0] ERR_MOV_DST  = 2'd1;
    localparam logic [ERR_W-1:0] ERR_BAD_JUMP = 2'd2;
    localparam logic [ERR_W-1:0] ERR_DIV_ZERO = 2'd3;

    // One decoded instruction
    typedef struct packed {
        logic [OPC_W-1:0]         opcode;
        logic                     src_is_reg;
        logic [REG_IDX_W-1:0]     src_reg;
        logic signed [DATA_W-1:0] src_imm;
        logic                     dst_is_reg;
        logic [REG_IDX_W-1:0]     dst_reg;
        logic signed [DATA_W-1:0] dst_imm;
        logic signed [PC_W-1:0]   jump_target;
        logic signed [DATA_W-1:0] read_value;
    } t_item;

    // One result
    typedef struct packed {
        logic [PC_W-1:0]          next_pc;
        logic                     print_valid;
        logic signed [DATA_W-1:0] print_value;
        logic [ERR_W-1:0]         error_code;
        logic                     halted;
    } t_result;

    // Controller to datapath
    typedef struct packed {
        logic load_in;
        logic alu;
        logic div_start;
        logic commit;
    } t_cmd;

    // Datapath to controller
    typedef struct packed {
        logic div_go;
        logic div_done;
    } t_sts;

endpackage

`default_nettype wire

[sv/fre_if.sv]
// Handshake channel interfaces: instruction input, result output, configuration write.
`default_nettype none

interface fre_in_if;
    logic                              valid;
    logic                              ready;
    logic [fre_pkg::OPC_W-1:0]         opcode;
    logic                              src_is_reg;
    logic [fre_pkg::REG_IDX_W-1:0]     src_reg;
    logic signed [fre_pkg::DATA_W-1:0] src_imm;
    logic                              dst_is_reg;
    logic [fre_pkg::REG_IDX_W-1:0]     dst_reg;
    logic signed [fre_pkg::DATA_W-1:0] dst_imm;
    logic signed [fre_pkg::PC_W-1:0]   jump_target;
    logic signed [fre_pkg::DATA_W-1:0] read_value;

    modport source (
        output valid, opcode, src_is_reg, src_reg, src_imm, dst_is_reg, dst_reg,
               dst_imm, jump_target, read_value,
        input  ready
    );
    modport sink (
        input  valid, opcode, src_is_reg, src_reg, src_imm, dst_is_reg, dst_reg,
               dst_imm, jump_target, read_value,
        output ready
    );
endinterface

interface fre_out_if;
    logic                              valid;
    logic                              ready;
    logic [fre_pkg::PC_W-1:0]          next_pc;
    logic                              print_valid;
    logic signed [fre_pkg::DATA_W-1:0] print_value;
    logic [fre_pkg::ERR_W-1:0]         error_code;
    logic                              halted;

    modport source (
        output valid, next_pc, print_valid, print_value, error_code, halted,
        input  ready
    );
    modport sink (
        input  valid, next_pc, print_valid, print_value, error_code, halted,
        output ready
    );
endinterface

interface fre_cfg_if;
    logic                      valid;
    logic                      ready;
    logic [fre_pkg::PC_W-1:0]  program_length;

    modport source (
        output valid, program_length,
        input  ready
    );
    modport sink (
        input  valid, program_length,
        output ready
    );
endinterface

`default_nettype wire

[sv/fre_ram.sv]
// Generic RAM: one write port, two read ports with registered read data.
`default_nettype none

module fre_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 4
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr0,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr1,
    output logic      [WIDTH-1:0]         o_rdata0,
    output logic      [WIDTH-1:0]         o_rdata1
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write and registered reads
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata0 <= r_mem[i_raddr0];
        o_rdata1 <= r_mem[i_raddr1];
    end

endmodule

`default_nettype wire

[sv/fre_div.sv]
// Iterative signed divider, one quotient bit per cycle, truncating toward zero.
`default_nettype none

module fre_div (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_start,
    input  wire logic signed [fre_pkg::DATA_W-1:0] i_dividend,
    input  wire logic signed [fre_pkg::DATA_W-1:0] i_divisor,
    output logic                                   o_done,
    output logic signed [fre_pkg::DATA_W-1:0]      o_quotient
);

    localparam int unsigned W = fre_pkg::DATA_W;

    logic                          r_busy;
    logic                          r_done;
    logic [fre_pkg::DIV_CNT_W-1:0] r_cnt;
    logic [W-1:0]                  r_rem;
    logic [W-1:0]                  r_quo;
    logic [W-1:0]                  r_dsr;
    logic                          r_neg;

    logic [W:0]   rem_sh;
    logic [W:0]   diff;
    logic [W-1:0] dvd_mag;
    logic [W-1:0] dsr_mag;

    // Magnitudes of the operands and one restoring step
    always_comb begin
        dvd_mag = i_dividend[W-1] ? W'(-i_dividend) : W'(i_dividend);
        dsr_mag = i_divisor[W-1]  ? W'(-i_divisor)  : W'(i_divisor);
        rem_sh  = {r_rem, r_quo[W-1]};
        diff    = rem_sh - {1'b0, r_dsr};
    end

    // Control: busy for one step per quotient bit, then pulse done
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= r_busy && (r_cnt == fre_pkg::DIV_CNT_W'(W - 1));
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == fre_pkg::DIV_CNT_W'(W - 1)) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    // Data: shift the dividend through the quotient register
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= dvd_mag;
            r_dsr <= dsr_mag;
            r_neg <= i_dividend[W-1] ^ i_divisor[W-1];
        end else if (r_busy) begin
            if (!diff[W]) begin
                r_rem <= diff[W-1:0];
                r_quo <= {r_quo[W-2:0], 1'b1};
            end else begin
                r_rem <= rem_sh[W-1:0];
                r_quo <= {r_quo[W-2:0], 1'b0};
            end
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_neg ? -$signed(r_quo) : $signed(r_quo);

endmodule

`default_nettype wire

[sv/fre_dp.sv]
// Datapath: instruction register, register file, ALU, program counter and result register.
`default_nettype none

module fre_dp (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire fre_pkg::t_cmd                i_cmd,
    output fre_pkg::t_sts                     o_sts,
    input  wire fre_pkg::t_item               i_item,
    input  wire logic                         i_cfg_we,
    input  wire logic [fre_pkg::PC_W-1:0]     i_cfg_len,
    output fre_pkg::t_result                  o_result
);

    localparam int unsigned W  = fre_pkg::DATA_W;
    localparam int unsigned PW = fre_pkg::PC_W;

    fre_pkg::t_item                  r_item;
    logic [PW-1:0]                   r_len;
    logic [PW-1:0]                   r_pc;
    logic [fre_pkg::NUM_REGS-1:0]    r_vld;
    logic signed [W-1:0]             r_res;
    logic                            r_wr;
    logic [fre_pkg::REG_IDX_W-1:0]   r_widx;
    logic [fre_pkg::ERR_W-1:0]       r_err;
    logic [PW-1:0]                   r_next;
    logic                            r_pv;
    logic signed [W-1:0]             r_pval;
    fre_pkg::t_result                r_result;

    logic signed [W-1:0]             n_res;
    logic                            n_wr;
    logic [fre_pkg::REG_IDX_W-1:0]   n_widx;
    logic [fre_pkg::ERR_W-1:0]       n_err;
    logic [PW-1:0]                   n_next;
    logic                            n_pv;
    logic signed [W-1:0]             n_pval;

    logic [W-1:0]                    rdata0;
    logic [W-1:0]                    rdata1;
    logic signed [W-1:0]             opa;
    logic signed [W-1:0]             opb;
    logic [PW-1:0]                   len_eff;
    logic [PW-1:0]                   pc_inc;
    logic                            tgt_ok;
    logic                            take;
    logic                            div_done;
    logic signed [W-1:0]             quotient;

    // Register file storage; entries never written read as zero
    fre_ram #(
        .WIDTH (W),
        .DEPTH (fre_pkg::NUM_REGS)
    ) u_rf (
        .i_clk    (i_clk),
        .i_we     (i_cmd.commit && r_wr),
        .i_waddr  (r_widx),
        .i_wdata  (r_res),
        .i_raddr0 (r_item.src_reg),
        .i_raddr1 (r_item.dst_reg),
        .o_rdata0 (rdata0),
        .o_rdata1 (rdata1)
    );

    // Divider, used only by the divide instruction
    fre_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (opa),
        .i_divisor  (opb),
        .o_done     (div_done),
        .o_quotient (quotient)
    );

    // Operand selection, jump check and program counter increment
    always_comb begin
        opa     = r_item.src_is_reg
                ? (r_vld[r_item.src_reg] ? $signed(rdata0) : '0) : r_item.src_imm;
        opb     = r_item.dst_is_reg
                ? (r_vld[r_item.dst_reg] ? $signed(rdata1) : '0) : r_item.dst_imm;
        len_eff = (r_len > fre_pkg::LEN_MAX) ? fre_pkg::LEN_MAX : r_len;
        pc_inc  = r_pc + 1'b1;
        tgt_ok  = !r_item.jump_target[PW-1] && (PW'(r_item.jump_target) <= len_eff);
    end

    // Execute the instruction
    always_comb begin
        n_res  = '0;
        n_wr   = 1'b0;
        n_widx = r_item.dst_reg;
        n_err  = fre_pkg::ERR_NONE;
        n_pv   = 1'b0;
        n_pval = '0;
        take   = 1'b0;
        unique case (r_item.opcode)
            fre_pkg::OP_READ: begin
                n_res  = r_item.read_value;
                n_wr   = r_item.src_is_reg;
                n_widx = r_item.src_reg;
            end
            fre_pkg::OP_PRINT: begin
                n_pv   = 1'b1;
                n_pval = opa;
            end
            fre_pkg::OP_MOV: begin
                n_res = opa;
                n_wr  = r_item.dst_is_reg;
                if (!r_item.dst_is_reg) begin
                    n_err = fre_pkg::ERR_MOV_DST;
                end
            end
            fre_pkg::OP_ADD: begin
                n_res = opa + opb;
                n_wr  = r_item.dst_is_reg;
            end
            fre_pkg::OP_SUB: begin
                n_res = opb - opa;
                n_wr  = r_item.dst_is_reg;
            end
            fre_pkg::OP_MUL: begin
                n_res = opa * opb;
                n_wr  = r_item.dst_is_reg;
            end
            fre_pkg::OP_DIV: begin
                if (opb == '0) begin
                    n_err = fre_pkg::ERR_DIV_ZERO;
                end else begin
                    n_wr = r_item.dst_is_reg;
                end
            end
            fre_pkg::OP_JMP: take = 1'b1;
            fre_pkg::OP_JE:  take = (opa == opb);
            fre_pkg::OP_JNE: take = (opa != opb);
            fre_pkg::OP_JG:  take = (opa > opb);
            fre_pkg::OP_JGE: take = (opa >= opb);
            fre_pkg::OP_JL:  take = (opa < opb);
            fre_pkg::OP_JLE: take = (opa <= opb);
            default: ;
        endcase
        n_next = pc_inc;
        if (take) begin
            if (tgt_ok) begin
                n_next = PW'(r_item.jump_target);
            end else begin
                n_err = fre_pkg::ERR_BAD_JUMP;
            end
        end
    end

    // Control state: program counter, length, entry valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc  <= '0;
            r_len <= '0;
            r_vld <= '0;
        end else begin
            if (i_cfg_we) begin
                r_len <= i_cfg_len;
            end
            if (i_cmd.commit) begin
                r_pc <= r_next;
                if (r_wr) begin
                    r_vld[r_widx] <= 1'b1;
                end
            end
        end
    end

    // Payload: hold the item, latch the execution outcome, build the result
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_item <= i_item;
        end
        if (i_cmd.alu) begin
            r_res  <= n_res;
            r_wr   <= n_wr;
            r_widx <= n_widx;
            r_err  <= n_err;
            r_next <= n_next;
            r_pv   <= n_pv;
            r_pval <= n_pval;
        end else if (div_done) begin
            r_res <= quotient;
        end
        if (i_cmd.commit) begin
            r_result.next_pc     <= r_next;
            r_result.print_valid <= r_pv;
            r_result.print_value <= r_pval;
            r_result.error_code  <= r_err;
            r_result.halted      <= (r_next >= len_eff);
        end
    end

    assign o_sts.div_go   = (r_item.opcode == fre_pkg::OP_DIV) && (opb != '0);
    assign o_sts.div_done = div_done;
    assign o_result       = r_result;

endmodule

`default_nettype wire

[sv/fre_ctrl.sv]
// Controller: sequences one instruction through read, execute, divide and commit.
`default_nettype none

module fre_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_in_valid,
    output logic               o_in_ready,
    output logic               o_out_valid,
    input  wire logic          i_out_ready,
    input  wire fre_pkg::t_sts i_sts,
    output fre_pkg::t_cmd      o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_EXEC,
        S_DIV,
        S_FIN
    } t_state;

    t_state r_state;
    logic   r_in_ready;
    logic   r_out_valid;
    logic   out_free;

    assign out_free = !r_out_valid || i_out_ready;

    // Commands to the datapath
    always_comb begin
        o_cmd.load_in   = (r_state == S_IDLE) && i_in_valid && r_in_ready;
        o_cmd.alu       = (r_state == S_EXEC);
        o_cmd.div_start = (r_state == S_EXEC) && i_sts.div_go;
        o_cmd.commit    = (r_state == S_FIN) && out_free;
    end

    // State and handshake flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_in_ready  <= 1'b1;
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_in_valid && r_in_ready) begin
                        r_in_ready <= 1'b0;
                        r_state    <= S_READ;
                    end
                end
                S_READ: begin
                    r_state <= S_EXEC;
                end
                S_EXEC: begin
                    r_state <= i_sts.div_go ? S_DIV : S_FIN;
                end
                S_DIV: begin
                    if (i_sts.div_done) begin
                        r_state <= S_FIN;
                    end
                end
                S_FIN: begin
                    if (out_free) begin
                        r_out_valid <= 1'b1;
                        r_in_ready  <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_in_ready  = r_in_ready;
    assign o_out_valid = r_out_valid;

endmodule

`default_nettype wire

[sv/four_register_instruction_executor.sv]
// Each accepted item passes through the read, execute and finish states; a divide by nonzero
// also passes through the divide state. Items go one at a time; the divider retires
// one quotient bit per cycle. The result register lets the next
// item enter while a result waits. Reset (synchronous, active low) clears the
// registers to zero, the program counter and program length to zero, and empties the
// result register; the register file needs no clearing pass.
`default_nettype none

module four_register_instruction_executor (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    fre_in_if.sink     i_in,
    fre_cfg_if.sink    i_cfg,
    fre_out_if.source  o_out
);

    fre_pkg::t_cmd    cmd;
    fre_pkg::t_sts    sts;
    fre_pkg::t_item   item;
    fre_pkg::t_result result;
    logic             in_ready;
    logic             out_valid;

    // Gather the input item
    always_comb begin
        item.opcode      = i_in.opcode;
        item.src_is_reg  = i_in.src_is_reg;
        item.src_reg     = i_in.src_reg;
        item.src_imm     = i_in.src_imm;
        item.dst_is_reg  = i_in.dst_is_reg;
        item.dst_reg     = i_in.dst_reg;
        item.dst_imm     = i_in.dst_imm;
        item.jump_target = i_in.jump_target;
        item.read_value  = i_in.read_value;
    end

    fre_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .o_in_ready  (in_ready),
        .o_out_valid (out_valid),
        .i_out_ready (o_out.ready),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    fre_dp u_dp (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cmd     (cmd),
        .o_sts     (sts),
        .i_item    (item),
        .i_cfg_we  (i_cfg.valid),
        .i_cfg_len (i_cfg.program_length),
        .o_result  (result)
    );

    // Drive the channels
    assign i_in.ready        = in_ready;
    assign i_cfg.ready       = 1'b1;
    assign o_out.valid       = out_valid;
    assign o_out.next_pc     = result.next_pc;
    assign o_out.print_valid = result.print_valid;
    assign o_out.print_value = result.print_value;
    assign o_out.error_code  = result.error_code;
    assign o_out.halted      = result.halted;

endmodule

`default_nettype wire
